/* rtl/core/tmf_pkg.sv */
// Package for the timed message FIFO.
// Holds sizes, operation codes, controller state encoding and the
// command and status bundles shared by the controller and datapath.
package tmf_pkg;

	localparam int QUEUE_DEPTH = 3;
	localparam int TIME_BITS   = 48;

	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DUR_IN_W = 10;
	localparam int DUR_W    = 9;
	localparam int US_W     = 20;
	localparam int PROD_W   = DUR_W + US_W;

	localparam logic [DUR_W-1:0] DUR_MIN   = DUR_W'(1);
	localparam logic [DUR_W-1:0] DUR_MAX   = DUR_W'(300);
	localparam logic [US_W-1:0]  US_PER_S  = US_W'(1000000);

	localparam int TEXT_W  = 16;
	localparam int COLOR_W = 8;
	localparam int MODE_W  = 2;
	localparam int PAYLOAD_W = TEXT_W + 3 * COLOR_W + MODE_W;
	localparam int SLOT_W    = TIME_BITS + PAYLOAD_W;

	localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INVALID = 2'd3;

	typedef enum logic [1:0] {
		OP_PUSH  = 2'd0,
		OP_QUERY = 2'd1,
		OP_POP   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_MUL    = 6'b000010,
		ST_WRITE  = 6'b000100,
		ST_READ   = 6'b001000,
		ST_CHECK  = 6'b010000,
		ST_FINISH = 6'b100000
	} state_t;

	typedef struct packed {
		logic latch;
		logic mul;
		logic write;
		logic advance;
		logic take;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic expired;
		logic out_free;
	} status_t;

endpackage

/* rtl/core/tmf_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used for the message slots of the timed message FIFO.
module tmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/tmf_ctrl.sv */
// Controller state machine of the timed message FIFO.
// Depends on tmf_pkg; drives commands to tmf_dp and reads its status.
module tmf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       op,
	output logic             in_stall,
	input  tmf_pkg::status_t sts,
	output tmf_pkg::cmd_t    cmd
);

	tmf_pkg::state_t state_q;
	tmf_pkg::state_t state_d;
	tmf_pkg::op_t    in_op;
	logic            accept;

	assign in_op    = tmf_pkg::op_t'(op);
	assign in_stall = (state_q != tmf_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			tmf_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.latch = 1'b1;
					case (in_op)
						tmf_pkg::OP_PUSH:  state_d = tmf_pkg::ST_MUL;
						tmf_pkg::OP_QUERY: state_d = tmf_pkg::ST_READ;
						tmf_pkg::OP_POP:   state_d = tmf_pkg::ST_READ;
						default:           state_d = tmf_pkg::ST_FINISH;
					endcase
				end
			end
			tmf_pkg::ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = tmf_pkg::ST_WRITE;
			end
			tmf_pkg::ST_WRITE: begin
				cmd.write = 1'b1;
				state_d   = tmf_pkg::ST_FINISH;
			end
			tmf_pkg::ST_READ: begin
				state_d = tmf_pkg::ST_CHECK;
			end
			tmf_pkg::ST_CHECK: begin
				state_d = tmf_pkg::ST_FINISH;
				if (!sts.empty) begin
					if (sts.op == tmf_pkg::OP_POP) begin
						cmd.take    = 1'b1;
						cmd.advance = 1'b1;
					end else if (sts.expired) begin
						cmd.advance = 1'b1;
						state_d     = tmf_pkg::ST_READ;
					end
				end
			end
			tmf_pkg::ST_FINISH: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = tmf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tmf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/core/tmf_dp.sv */
// Datapath of the timed message FIFO: input latch, expiry arithmetic,
// ring pointers, slot RAM and result register. Depends on tmf_pkg and tmf_ram.
module tmf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmf_pkg::cmd_t                       cmd,
	output tmf_pkg::status_t                    sts,
	input  logic [1:0]                          op,
	input  logic [tmf_pkg::TIME_BITS-1:0]       now_us,
	input  logic [tmf_pkg::DUR_IN_W-1:0]        duration_s,
	input  logic [tmf_pkg::COLOR_W-1:0]         color_red,
	input  logic [tmf_pkg::COLOR_W-1:0]         color_green,
	input  logic [tmf_pkg::COLOR_W-1:0]         color_blue,
	input  logic [tmf_pkg::MODE_W-1:0]          show_mode,
	input  logic [tmf_pkg::TEXT_W-1:0]          text_ref,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                dropped_oldest,
	output logic                                pending,
	output logic [1:0]                          queued_count,
	output logic                                entry_valid,
	output logic [tmf_pkg::TEXT_W-1:0]          out_text_ref,
	output logic [tmf_pkg::COLOR_W-1:0]         out_red,
	output logic [tmf_pkg::COLOR_W-1:0]         out_green,
	output logic [tmf_pkg::COLOR_W-1:0]         out_blue,
	output logic [tmf_pkg::MODE_W-1:0]          out_mode,
	output logic [tmf_pkg::TIME_BITS-1:0]       out_expiry_us
);

	localparam int IDX_W = tmf_pkg::IDX_W;
	localparam int CNT_W = tmf_pkg::CNT_W;
	localparam int TB    = tmf_pkg::TIME_BITS;
	localparam int PW    = tmf_pkg::PAYLOAD_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(tmf_pkg::QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(tmf_pkg::QUEUE_DEPTH);
	localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W+1)'(tmf_pkg::QUEUE_DEPTH);

	tmf_pkg::op_t                 op_q;
	logic [TB-1:0]                now_q;
	logic [tmf_pkg::DUR_W-1:0]    dur_q;
	logic [PW-1:0]                pl_q;
	logic [tmf_pkg::PROD_W-1:0]   prod_q;
	logic [IDX_W-1:0]             head_q;
	logic [CNT_W-1:0]             count_q;
	logic                         drop_q;
	logic                         valid_q;
	logic [PW-1:0]                pop_pl_q;
	logic [TB-1:0]                pop_exp_q;
	logic                         out_valid_q;
	logic                         out_drop_q;
	logic                         out_pend_q;
	logic [CNT_W-1:0]             out_cnt_q;
	logic                         out_entry_q;
	logic [PW-1:0]                out_pl_q;
	logic [TB-1:0]                out_exp_q;

	logic [tmf_pkg::DUR_W-1:0]    dur_clamp;
	logic [tmf_pkg::MODE_W-1:0]   mode_fix;
	logic [TB-1:0]                new_exp;
	logic [CNT_W:0]               tail_sum;
	logic [IDX_W-1:0]             tail_idx;
	logic [IDX_W-1:0]             head_next;
	logic                         full;
	logic [IDX_W-1:0]             waddr;
	logic [tmf_pkg::SLOT_W-1:0]   rdata;
	logic [TB-1:0]                rd_exp;
	logic [PW-1:0]                rd_pl;

	always_comb begin
		if (duration_s == '0) begin
			dur_clamp = tmf_pkg::DUR_MIN;
		end else if (duration_s > tmf_pkg::DUR_IN_W'(tmf_pkg::DUR_MAX)) begin
			dur_clamp = tmf_pkg::DUR_MAX;
		end else begin
			dur_clamp = duration_s[tmf_pkg::DUR_W-1:0];
		end
	end

	assign mode_fix  = (show_mode == tmf_pkg::MODE_INVALID) ? tmf_pkg::MODE_STATIC : show_mode;
	assign new_exp   = now_q + TB'(prod_q);
	assign full      = (count_q == FULL_CNT);
	assign tail_sum  = (CNT_W+1)'(head_q) + (CNT_W+1)'(count_q);
	assign tail_idx  = (tail_sum >= DEPTH_SUM) ? IDX_W'(tail_sum - DEPTH_SUM) : IDX_W'(tail_sum);
	assign head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
	assign waddr     = full ? head_q : tail_idx;
	assign rd_exp    = rdata[tmf_pkg::SLOT_W-1 -: TB];
	assign rd_pl     = rdata[PW-1:0];

	tmf_ram #(
		.WIDTH (tmf_pkg::SLOT_W),
		.DEPTH (tmf_pkg::QUEUE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.write),
		.waddr (waddr),
		.wdata ({new_exp, pl_q}),
		.raddr (head_q),
		.rdata (rdata)
	);

	assign sts.op       = op_q;
	assign sts.empty    = (count_q == '0);
	assign sts.expired  = (now_q >= rd_exp);
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q      <= tmf_pkg::op_t'(op);
			now_q     <= now_us;
			dur_q     <= dur_clamp;
			pl_q      <= {text_ref, color_red, color_green, color_blue, mode_fix};
			drop_q    <= 1'b0;
			valid_q   <= 1'b0;
			pop_pl_q  <= '0;
			pop_exp_q <= '0;
		end
		if (cmd.mul) begin
			prod_q <= tmf_pkg::PROD_W'(dur_q) * tmf_pkg::PROD_W'(tmf_pkg::US_PER_S);
		end
		if (cmd.write) begin
			drop_q <= full;
		end
		if (cmd.take) begin
			pop_pl_q  <= rd_pl;
			pop_exp_q <= rd_exp;
			valid_q   <= (now_q < rd_exp);
		end
		if (cmd.load_out) begin
			out_drop_q  <= drop_q;
			out_pend_q  <= (count_q != '0);
			out_cnt_q   <= count_q;
			out_entry_q <= valid_q;
			out_pl_q    <= pop_pl_q;
			out_exp_q   <= pop_exp_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				if (full) begin
					head_q <= head_next;
				end else begin
					count_q <= count_q + 1'b1;
				end
			end else if (cmd.advance) begin
				head_q  <= head_next;
				count_q <= count_q - 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign dropped_oldest = out_drop_q;
	assign pending        = out_pend_q;
	assign queued_count   = 2'(out_cnt_q);
	assign entry_valid    = out_entry_q;
	assign out_text_ref   = out_pl_q[PW-1 -: tmf_pkg::TEXT_W];
	assign out_red        = out_pl_q[3*tmf_pkg::COLOR_W+tmf_pkg::MODE_W-1 -: tmf_pkg::COLOR_W];
	assign out_green      = out_pl_q[2*tmf_pkg::COLOR_W+tmf_pkg::MODE_W-1 -: tmf_pkg::COLOR_W];
	assign out_blue       = out_pl_q[tmf_pkg::COLOR_W+tmf_pkg::MODE_W-1 -: tmf_pkg::COLOR_W];
	assign out_mode       = out_pl_q[tmf_pkg::MODE_W-1:0];
	assign out_expiry_us  = out_exp_q;

endmodule

/* rtl/core/timed_message_fifo.sv */
// Top level of the timed message FIFO.
// Depends on tmf_pkg, tmf_ctrl and tmf_dp.
//
//  channel  handshake            words carried
//  in       in_valid / in_stall  op, now_us, duration_s, color_*, show_mode, text_ref
//  out      out_valid / out_stall dropped_oldest, pending, queued_count, entry_valid, out_*
//
// A push passes the MUL, WRITE and FINISH states before the next acceptance; a pop READ, CHECK
// and FINISH; an unused op only FINISH. A query repeats READ and CHECK for each expired head it
// drops (at most 3), since each head needs one slot RAM read and one compare.
// The reset clears the ring pointers and the controller; the slot RAM is not cleared.
// A word is accepted while a finished result still waits on a stalled output.
module timed_message_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [tmf_pkg::TIME_BITS-1:0] now_us,
	input  logic [tmf_pkg::DUR_IN_W-1:0]  duration_s,
	input  logic [tmf_pkg::COLOR_W-1:0]   color_red,
	input  logic [tmf_pkg::COLOR_W-1:0]   color_green,
	input  logic [tmf_pkg::COLOR_W-1:0]   color_blue,
	input  logic [tmf_pkg::MODE_W-1:0]    show_mode,
	input  logic [tmf_pkg::TEXT_W-1:0]    text_ref,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          dropped_oldest,
	output logic                          pending,
	output logic [1:0]                    queued_count,
	output logic                          entry_valid,
	output logic [tmf_pkg::TEXT_W-1:0]    out_text_ref,
	output logic [tmf_pkg::COLOR_W-1:0]   out_red,
	output logic [tmf_pkg::COLOR_W-1:0]   out_green,
	output logic [tmf_pkg::COLOR_W-1:0]   out_blue,
	output logic [tmf_pkg::MODE_W-1:0]    out_mode,
	output logic [tmf_pkg::TIME_BITS-1:0] out_expiry_us
);

	tmf_pkg::cmd_t    cmd;
	tmf_pkg::status_t sts;

	tmf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.op       (op),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmf_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.op             (op),
		.now_us         (now_us),
		.duration_s     (duration_s),
		.color_red      (color_red),
		.color_green    (color_green),
		.color_blue     (color_blue),
		.show_mode      (show_mode),
		.text_ref       (text_ref),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.dropped_oldest (dropped_oldest),
		.pending        (pending),
		.queued_count   (queued_count),
		.entry_valid    (entry_valid),
		.out_text_ref   (out_text_ref),
		.out_red        (out_red),
		.out_green      (out_green),
		.out_blue       (out_blue),
		.out_mode       (out_mode),
		.out_expiry_us  (out_expiry_us)
	);

endmodule

/* rtl/core/tmf_checker.sv */
// Port-level checker for the timed message FIFO and its bind statement.
// Depends on tmf_pkg and the ports of timed_message_fifo.
module tmf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          dropped_oldest,
	input logic                          pending,
	input logic [1:0]                    queued_count,
	input logic                          entry_valid,
	input logic [tmf_pkg::TIME_BITS-1:0] out_expiry_us
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_expiry_us))
		else $error("A stalled result word changed or vanished.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("An accepted word did not make the block busy.");

	a_pending_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending == (queued_count != 2'd0)))
		else $error("Pending flag disagrees with the entry count.");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_oldest |->
			!entry_valid && (queued_count == 2'(tmf_pkg::QUEUE_DEPTH)))
		else $error("A drop was reported without a full queue.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (queued_count <= 2'(tmf_pkg::QUEUE_DEPTH)))
		else $error("Entry count exceeds the queue depth.");

endmodule

bind timed_message_fifo tmf_checker u_tmf_checker (.*);
